>>> hdl/assert_macros.svh
// assertion macros shared by the decoder modules
// no dependencies; defining SYNTH turns every use into nothing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define CFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define CFD_ASSERT(lbl, clk, rstn, prop, msg)
`define CFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> hdl/cfd_pkg.sv
// types, codes and constants of the can signal field decoder
// no dependencies
`timescale 1ns / 1ps
package cfd_pkg;

  localparam int TableSlotsDef     = 16;
  localparam int FieldsPerEntryDef = 8;
  localparam int ParamsPerField    = 4;
  localparam int MaxResults        = 8;
  localparam int QueueDepth        = 2;

  typedef enum logic [2:0] {
    KIND_FRAME  = 3'd0,
    KIND_ENTRY  = 3'd1,
    KIND_LAYOUT = 3'd2,
    KIND_PARAM  = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    FORM_PASS  = 2'd0,
    FORM_SCALE = 2'd1,
    FORM_MAP   = 2'd2,
    FORM_MASK  = 2'd3
  } formula_e;

  typedef enum logic [1:0] {
    TYPE_RAW    = 2'd0,
    TYPE_INT8   = 2'd1,
    TYPE_INT16  = 2'd2,
    TYPE_RAW_HI = 2'd3
  } ftype_e;

  typedef enum logic [2:0] {
    F_IDLE, F_RD, F_CMP, F_FRD, F_FPUSH, F_PUSH1
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE, B_PREP, B_MUL, B_DST, B_DIV, B_OUT
  } back_state_e;

  typedef struct packed {
    logic                                matched;
    logic                                fvalid;
    logic                                last;
    logic [14:0]                         layout;
    logic [ParamsPerField-1:0][31:0]     params;
    logic [63:0]                         bytes;
    logic [31:0]                         hits;
    logic [31:0]                         misses;
  } cfd_task_t;

  typedef struct packed {
    logic        matched;
    logic        fvalid;
    logic        last;
    logic [4:0]  target;
    logic [31:0] value;
    logic [31:0] hits;
    logic [31:0] misses;
  } cfd_res_t;

endpackage

>>> hdl/cfd_fifo.sv
// small register queue, used between front and back and at the result side
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfd_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);
  localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CFD_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, push_i, !full_o, "transaction pushed into full queue")
  `CFD_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "queue count out of range")

endmodule

>>> hdl/cfd_div.sv
// iterative signed divider: 64-bit dividend by 32-bit divisor, low 32 quotient bits
// two quotient bits per cycle, truncates toward zero
`timescale 1ns / 1ps
module cfd_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic signed [31:0] divisor_i,
  output logic               done_o,
  output logic [31:0]        quot_o
);
  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [32:0] rem_q, rem_d;
  logic [63:0] dq_q, dq_d;
  logic [31:0] dvs_q;

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    for (int i = 0; i < 2; i++) begin
      rem_d = {rem_d[31:0], dq_d[63]};
      dq_d  = {dq_d[62:0], 1'b0};
      if (rem_d >= {1'b0, dvs_q}) begin
        rem_d    = rem_d - {1'b0, dvs_q};
        dq_d[0]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i[63] ? (~dividend_i + 64'd1) : dividend_i;
      dvs_q <= divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
      neg_q <= dividend_i[63] ^ divisor_i[31];
      rem_q <= '0;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (~dq_q[31:0] + 32'd1) : dq_q[31:0];

endmodule

>>> hdl/cfd_back.sv
// back end: gathers field bytes, applies the formula, queues results
// depends on cfd_pkg, cfd_div and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfd_back
  import cfd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfd_task_t task_i,
  input  logic      task_empty_i,
  output logic      task_pop_o,
  output cfd_res_t  res_o,
  output logic      res_push_o,
  input  logic      res_full_i
);
  back_state_e        state_q, state_d;
  cfd_task_t          tsk_q;
  logic signed [31:0] a_q, a_d, b_q, b_d, dv_q, dv_d;
  logic [31:0]        off_q, off_d, val_q, val_d;
  logic signed [63:0] prod_q, prod_d;
  logic               div_start, div_done;
  logic [31:0]        div_quot;
  logic [31:0]        raw, masked, run, p0, p1, p2, p3;
  logic [4:0]         shamt;

  function automatic logic [31:0] gather(logic [63:0] b, logic [14:0] lay);
    logic [31:0] r;
    logic [2:0]  nm1;
    logic [3:0]  pos;
    logic [7:0]  byt;
    r   = '0;
    nm1 = {1'b0, lay[4:3]};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) <= nm1) begin
        pos = {1'b0, lay[2:0]} + (lay[5] ? (4'(nm1) - 4'(i)) : 4'(i));
        byt = (pos > 4'd7) ? 8'd0 : b[8 * (7 - pos[2:0]) +: 8];
        r   = {r[23:0], byt};
      end
    end
    case (lay[7:6])
      TYPE_INT8:  r = {{24{r[7]}}, r[7:0]};
      TYPE_INT16: r = {{16{r[15]}}, r[15:0]};
      default: ;
    endcase
    return r;
  endfunction

  assign p0     = tsk_q.params[0];
  assign p1     = tsk_q.params[1];
  assign p2     = tsk_q.params[2];
  assign p3     = tsk_q.params[3];
  assign raw    = gather(tsk_q.bytes, tsk_q.layout);
  assign masked = raw & p0;
  assign run    = p1 - p0;
  // shift amounts past 31 saturate
  assign shamt  = (p1 > 32'd31) ? 5'd31 : p1[4:0];

  cfd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (dv_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    a_d        = a_q;
    b_d        = b_q;
    dv_d       = dv_q;
    off_d      = off_q;
    val_d      = val_q;
    prod_d     = prod_q;
    task_pop_o = 1'b0;
    res_push_o = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!task_empty_i) begin
          task_pop_o = 1'b1;
          state_d    = B_PREP;
        end
      end
      B_PREP: begin
        state_d = B_OUT;
        if (!tsk_q.fvalid) begin
          val_d = '0;
        end else begin
          case (tsk_q.layout[9:8])
            FORM_SCALE: begin
              a_d     = raw;
              b_d     = (p0 == '0) ? 32'sd1 : p0;
              dv_d    = (p1 == '0) ? 32'sd1 : p1;
              off_d   = p2;
              state_d = B_MUL;
            end
            FORM_MAP: begin
              if (run == '0) begin
                val_d = p2;
              end else begin
                a_d     = raw - p0;
                b_d     = p3 - p2;
                dv_d    = run;
                off_d   = p2;
                state_d = B_MUL;
              end
            end
            FORM_MASK: val_d = 32'($signed(masked) >>> shamt);
            default:   val_d = raw;
          endcase
        end
      end
      B_MUL: begin
        prod_d  = a_q * b_q;
        state_d = B_DST;
      end
      B_DST: begin
        div_start = 1'b1;
        state_d   = B_DIV;
      end
      B_DIV: begin
        if (div_done) begin
          val_d   = div_quot + off_q;
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (task_pop_o) begin
      tsk_q <= task_i;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    dv_q   <= dv_d;
    off_q  <= off_d;
    val_q  <= val_d;
    prod_q <= prod_d;
  end

  always_comb begin
    res_o.matched = tsk_q.matched;
    res_o.fvalid  = tsk_q.fvalid;
    res_o.last    = tsk_q.last;
    res_o.target  = tsk_q.fvalid ? tsk_q.layout[14:10] : 5'd0;
    res_o.value   = val_q;
    res_o.hits    = tsk_q.hits;
    res_o.misses  = tsk_q.misses;
  end

  `CFD_ASSERT_IMP(a_div_done_state, clk_i, rst_ni, div_done, state_q == B_DIV, "divider finished outside the wait state")

endmodule

>>> hdl/cfd_front.sv
// front end: takes transactions, keeps the frame table, looks up frames and queues one
// task per field, or one for a miss or an entry with no fields; depends on cfd_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfd_front
  import cfd_pkg::*;
#(
  parameter int TABLE_SLOTS      = TableSlotsDef,
  parameter int FIELDS_PER_ENTRY = FieldsPerEntryDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [2:0]         kind_i,
  input  logic [15:0]        can_ident_i,
  input  logic [63:0]        frame_bytes_i,
  input  logic [3:0]         slot_i,
  input  logic [2:0]         field_slot_i,
  input  logic [1:0]         param_slot_i,
  input  logic signed [31:0] load_value_i,
  input  logic [14:0]        layout_i,
  output cfd_task_t          task_o,
  output logic               task_push_o,
  input  logic               task_full_i
);
  localparam int SW  = TABLE_SLOTS > 1 ? $clog2(TABLE_SLOTS) : 1;
  localparam int FD  = TABLE_SLOTS * FIELDS_PER_ENTRY;
  localparam int RW  = FD > 1 ? $clog2(FD) : 1;
  localparam int Cap = FIELDS_PER_ENTRY < MaxResults ? FIELDS_PER_ENTRY : MaxResults;

  front_state_e     state_q, state_d;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [SW-1:0]    scan_q, scan_d, hit_q, hit_d, wr_slot;
  logic [3:0]       fidx_q, fidx_d, cnt_q, cnt_d, load_cnt;
  logic [31:0]      hits_q, hits_d, misses_q, misses_d;
  logic             matched_q, matched_d;
  logic [15:0]      ident_q;
  logic [63:0]      bytes_q;
  logic             accept, slot_ok, fs_ok;
  logic [RW-1:0]    wr_row, rd_row;

  logic [15:0]      id_mem  [TABLE_SLOTS];
  logic [3:0]       cnt_mem [TABLE_SLOTS];
  logic [15:0]      ent_id_q;
  logic [3:0]       ent_cnt_q;
  logic [14:0]      lay_mem [FD];
  logic [31:0]      par_mem [ParamsPerField][FD];
  logic [14:0]      lay_rd_q;
  logic [ParamsPerField-1:0][31:0] par_rd_q;

  assign full_o  = state_q != F_IDLE;
  assign accept  = push_i && !full_o;
  assign slot_ok = {28'd0, slot_i} < 32'(TABLE_SLOTS);
  assign fs_ok   = {29'd0, field_slot_i} < 32'(FIELDS_PER_ENTRY);
  assign wr_slot = SW'(slot_i);
  assign wr_row  = RW'(32'(wr_slot) * FIELDS_PER_ENTRY + 32'(field_slot_i));
  assign rd_row  = RW'(32'(hit_q) * FIELDS_PER_ENTRY + 32'(fidx_q));

  // negative counts load zero, large ones the cap
  assign load_cnt = load_value_i[31] ? 4'd0 :
                    (load_value_i > 32'(Cap)) ? 4'(Cap) : load_value_i[3:0];

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_ENTRY && slot_ok) begin
      id_mem[wr_slot]  <= can_ident_i;
      cnt_mem[wr_slot] <= load_cnt;
    end
    ent_id_q  <= id_mem[scan_q];
    ent_cnt_q <= cnt_mem[scan_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_LAYOUT && slot_ok && fs_ok) begin
      lay_mem[wr_row] <= layout_i;
      for (int k = 0; k < ParamsPerField; k++) begin
        par_mem[k][wr_row] <= '0;
      end
    end
    if (accept && kind_i == KIND_PARAM && slot_ok && fs_ok) begin
      par_mem[param_slot_i][wr_row] <= load_value_i;
    end
    lay_rd_q <= lay_mem[rd_row];
    for (int k = 0; k < ParamsPerField; k++) begin
      par_rd_q[k] <= par_mem[k][rd_row];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ident_q <= can_ident_i;
      bytes_q <= frame_bytes_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    scan_d      = scan_q;
    hit_d       = hit_q;
    fidx_d      = fidx_q;
    cnt_d       = cnt_q;
    hits_d      = hits_q;
    misses_d    = misses_q;
    matched_d   = matched_q;
    task_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (push_i) begin
          case (kind_i)
            KIND_FRAME: begin
              scan_d  = '0;
              state_d = F_RD;
            end
            KIND_ENTRY: begin
              if (slot_ok) begin
                valid_d[wr_slot] = 1'b1;
              end
            end
            KIND_CLEAR: valid_d = '0;
            default: ;
          endcase
        end
      end
      F_RD: state_d = F_CMP;
      F_CMP: begin
        if (valid_q[scan_q] && ent_id_q == ident_q) begin
          hits_d    = hits_q + 32'd1;
          matched_d = 1'b1;
          hit_d     = scan_q;
          cnt_d     = ent_cnt_q;
          fidx_d    = '0;
          state_d   = (ent_cnt_q == 4'd0) ? F_PUSH1 : F_FRD;
        end else if (scan_q == SW'(TABLE_SLOTS - 1)) begin
          misses_d  = misses_q + 32'd1;
          matched_d = 1'b0;
          state_d   = F_PUSH1;
        end else begin
          scan_d  = scan_q + SW'(1);
          state_d = F_RD;
        end
      end
      F_FRD: state_d = F_FPUSH;
      F_FPUSH: begin
        if (!task_full_i) begin
          task_push_o = 1'b1;
          if (fidx_q == cnt_q - 4'd1) begin
            state_d = F_IDLE;
          end else begin
            fidx_d  = fidx_q + 4'd1;
            state_d = F_FRD;
          end
        end
      end
      F_PUSH1: begin
        if (!task_full_i) begin
          task_push_o = 1'b1;
          state_d     = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= F_IDLE;
      valid_q   <= '0;
      scan_q    <= '0;
      hit_q     <= '0;
      fidx_q    <= '0;
      cnt_q     <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      matched_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      scan_q    <= scan_d;
      hit_q     <= hit_d;
      fidx_q    <= fidx_d;
      cnt_q     <= cnt_d;
      hits_q    <= hits_d;
      misses_q  <= misses_d;
      matched_q <= matched_d;
    end
  end

  always_comb begin
    task_o.matched = matched_q;
    task_o.fvalid  = state_q == F_FPUSH;
    task_o.last    = (state_q == F_PUSH1) || (fidx_q == cnt_q - 4'd1);
    task_o.layout  = lay_rd_q;
    task_o.params  = par_rd_q;
    task_o.bytes   = bytes_q;
    task_o.hits    = hits_q;
    task_o.misses  = misses_q;
  end

  `CFD_ASSERT_IMP(a_task_room, clk_i, rst_ni, task_push_o, !task_full_i, "task pushed into full queue")
  `CFD_ASSERT_IMP(a_hit_step, clk_i, rst_ni, hits_q != $past(hits_q), hits_q == $past(hits_q) + 32'd1, "hit counter jumped")
  `CFD_ASSERT_IMP(a_one_counter, clk_i, rst_ni, hits_q != $past(hits_q), misses_q == $past(misses_q), "hit and miss in one frame")

endmodule

>>> hdl/can_signal_field_decoder_top.sv
// scanning: a frame reads and then compares the table slot by slot; each field then
// passes the back end, where scale formulas and map-range formulas with a nonzero range
// also use the multiplier and the 2-bit-per-cycle divider; load and clear items leave the front idle
// throughput: one item at a time in the front; results drain through queues
// reset: asynchronous active-low, clears valid bits, counters and queues; no clearing pass
`timescale 1ns / 1ps
module can_signal_field_decoder_top
  import cfd_pkg::*;
#(
  parameter int TABLE_SLOTS      = TableSlotsDef,
  parameter int FIELDS_PER_ENTRY = FieldsPerEntryDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         kind_i,
  input  logic [15:0]        can_ident_i,
  input  logic [63:0]        frame_bytes_i,
  input  logic [3:0]         slot_i,
  input  logic [2:0]         field_slot_i,
  input  logic [1:0]         param_slot_i,
  input  logic signed [31:0] load_value_i,
  input  logic [14:0]        layout_i,
  output logic               empty,
  input  logic               pop,
  output logic               matched_o,
  output logic               field_valid_o,
  output logic               last_o,
  output logic [4:0]         target_o,
  output logic signed [31:0] value_o,
  output logic [31:0]        matched_count_o,
  output logic [31:0]        unknown_count_o
);
  cfd_task_t ftask, btask;
  logic      ftask_push, tq_full, tq_empty, tq_pop;
  cfd_res_t  bres, ores;
  logic      bres_push, rq_full;

  cfd_front #(
    .TABLE_SLOTS      (TABLE_SLOTS),
    .FIELDS_PER_ENTRY (FIELDS_PER_ENTRY)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .can_ident_i   (can_ident_i),
    .frame_bytes_i (frame_bytes_i),
    .slot_i        (slot_i),
    .field_slot_i  (field_slot_i),
    .param_slot_i  (param_slot_i),
    .load_value_i  (load_value_i),
    .layout_i      (layout_i),
    .task_o        (ftask),
    .task_push_o   (ftask_push),
    .task_full_i   (tq_full)
  );

  cfd_fifo #(.T(cfd_task_t), .DEPTH(QueueDepth)) u_task_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ftask_push),
    .data_i  (ftask),
    .full_o  (tq_full),
    .pop_i   (tq_pop),
    .data_o  (btask),
    .empty_o (tq_empty)
  );

  cfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (btask),
    .task_empty_i (tq_empty),
    .task_pop_o   (tq_pop),
    .res_o        (bres),
    .res_push_o   (bres_push),
    .res_full_i   (rq_full)
  );

  cfd_fifo #(.T(cfd_res_t), .DEPTH(QueueDepth)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (bres_push),
    .data_i  (bres),
    .full_o  (rq_full),
    .pop_i   (pop),
    .data_o  (ores),
    .empty_o (empty)
  );

  assign matched_o       = ores.matched;
  assign field_valid_o   = ores.fvalid;
  assign last_o          = ores.last;
  assign target_o        = ores.target;
  assign value_o         = ores.value;
  assign matched_count_o = ores.hits;
  assign unknown_count_o = ores.misses;

endmodule
